// File: hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Request codes, status codes and fixed field widths shared by the
// generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int REQ_W    = 3;
  localparam int HANDLE_W = 32;
  localparam int SEL_W    = 6;
  localparam int SIZE_W   = 16;
  localparam int STAT_W   = 3;
  localparam int ARES_W   = 5;
  localparam int POS_W    = 32;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam req_t REQ_CREATE_ARCH = 3'd0;
  localparam req_t REQ_CREATE_ENT  = 3'd1;
  localparam req_t REQ_DESTROY     = 3'd2;
  localparam req_t REQ_EXISTS      = 3'd3;
  localparam req_t REQ_LOCATE      = 3'd4;

  localparam status_t STAT_OK        = 3'd0;
  localparam status_t STAT_NO_SLOT   = 3'd1;
  localparam status_t STAT_UNKNOWN   = 3'd2;
  localparam status_t STAT_TBL_FULL  = 3'd3;
  localparam status_t STAT_NOT_FOUND = 3'd4;

endpackage

// File: hdl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous ram: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/gha_kind_tbl.sv
// ----------------------------------------------------------------------------
// gha_kind_tbl
// Per-archetype element size and fill count. Entries are defined only after
// a create archetype request has written them.
// ----------------------------------------------------------------------------
module gha_kind_tbl
  import gha_pkg::*;
#(
  parameter int KINDS  = 32,
  parameter int KIND_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              wr_new,
  input  logic [KIND_W-1:0] wr_idx,
  input  logic [SIZE_W-1:0] wr_size,
  input  logic [POS_W-1:0]  wr_fill,
  input  logic [KIND_W-1:0] rd_idx,
  output logic [SIZE_W-1:0] rd_size,
  output logic [POS_W-1:0]  rd_fill
);

  logic [SIZE_W-1:0] size_r [KINDS];
  logic [POS_W-1:0]  fill_r [KINDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fill_r[wr_idx] <= wr_fill;
      if (wr_new) begin
        size_r[wr_idx] <= wr_size;
      end
    end
  end

  assign rd_size = size_r[rd_idx];
  assign rd_fill = fill_r[rd_idx];

endmodule

// File: hdl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Flow: EXEC does the read-modify-write of the slot ram; create entity reads the
// ring then the slot and writes the slot in GEN. DONE registers the result out
// once the output is free and may take the next request then; else IDLE takes it.
// Reset: a clearing pass over all 2^SLOT_BITS slots (1024 by default) rebuilds
// the free ring and zeroes the slot ram; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int SLOT_BITS = 10,
  parameter int MAX_KINDS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [HANDLE_W-1:0] in_entity_handle,
  input  logic [SEL_W-1:0]    in_archetype_sel,
  input  logic [SIZE_W-1:0]   in_element_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   out_status,
  output logic [HANDLE_W-1:0] out_handle_result,
  output logic [ARES_W-1:0]   out_archetype_result,
  output logic [POS_W-1:0]    out_position,
  output logic [POS_W-1:0]    out_byte_offset,
  output logic                out_is_live
);

  localparam int GEN_W   = HANDLE_W - SLOT_BITS;
  localparam int KIND_W  = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam int TOT_W   = $clog2(MAX_KINDS + 1);
  localparam int CMP_W   = (TOT_W > SEL_W) ? TOT_W : SEL_W;
  localparam int SLOTW_W = GEN_W + KIND_W + POS_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_GEN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [SLOT_BITS-1:0] clr_r, clr_nxt;
  logic [POS_W-1:0]     pop_r, pop_nxt;
  logic [POS_W-1:0]     push_r, push_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;

  req_t                 req_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [SEL_W-1:0]     sel_r;
  logic [SIZE_W-1:0]    size_r;

  status_t              rs_status_r, rs_status_nxt;
  logic [HANDLE_W-1:0]  rs_handle_r, rs_handle_nxt;
  logic [ARES_W-1:0]    rs_ares_r, rs_ares_nxt;
  logic [POS_W-1:0]     rs_pos_r, rs_pos_nxt;
  logic [SIZE_W-1:0]    rs_size_r, rs_size_nxt;
  logic                 rs_live_r, rs_live_nxt;
  logic [SLOT_BITS-1:0] new_slot_r, new_slot_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [HANDLE_W-1:0]  out_handle_r;
  logic [ARES_W-1:0]    out_ares_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [POS_W-1:0]     out_offs_r;
  logic                 out_live_r;

  logic                 out_free;
  logic                 in_acc;
  logic                 out_load;
  logic [POS_W+SIZE_W-1:0] prod;

  logic                 ring_we, ring_re;
  logic [SLOT_BITS-1:0] ring_waddr, ring_wdata, ring_rdata;
  logic                 slot_we, slot_re;
  logic [SLOT_BITS-1:0] slot_waddr, slot_raddr;
  logic [SLOTW_W-1:0]   slot_wdata, slot_rdata;

  logic                 kt_we, kt_new;
  logic [KIND_W-1:0]    kt_widx, kt_ridx;
  logic [SIZE_W-1:0]    kt_rsize;
  logic [POS_W-1:0]     kt_wfill, kt_rfill;

  logic [GEN_W-1:0]     slot_gen;
  logic [KIND_W-1:0]    slot_kind;
  logic [POS_W-1:0]     slot_pos;
  logic [SLOT_BITS-1:0] h_slot;
  logic [GEN_W-1:0]     h_gen;

  assign slot_gen  = slot_rdata[SLOTW_W-1 -: GEN_W];
  assign slot_kind = slot_rdata[POS_W +: KIND_W];
  assign slot_pos  = slot_rdata[POS_W-1:0];
  assign h_slot    = handle_r[SLOT_BITS-1:0];
  assign h_gen     = handle_r[HANDLE_W-1:SLOT_BITS];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_DONE) && out_free));
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && out_free;
  assign prod     = rs_pos_r * rs_size_r;

  gha_ram #(.WIDTH(SLOT_BITS), .ADDR_BITS(SLOT_BITS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (pop_r[SLOT_BITS-1:0]),
    .rdata (ring_rdata)
  );

  gha_ram #(.WIDTH(SLOTW_W), .ADDR_BITS(SLOT_BITS)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gha_kind_tbl #(.KINDS(MAX_KINDS), .KIND_W(KIND_W)) u_kind (
    .clk     (clk),
    .wr_en   (kt_we),
    .wr_new  (kt_new),
    .wr_idx  (kt_widx),
    .wr_size (size_r),
    .wr_fill (kt_wfill),
    .rd_idx  (kt_ridx),
    .rd_size (kt_rsize),
    .rd_fill (kt_rfill)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pop_nxt       = pop_r;
    push_nxt      = push_r;
    total_nxt     = total_r;
    rs_status_nxt = rs_status_r;
    rs_handle_nxt = rs_handle_r;
    rs_ares_nxt   = rs_ares_r;
    rs_pos_nxt    = rs_pos_r;
    rs_size_nxt   = rs_size_r;
    rs_live_nxt   = rs_live_r;
    new_slot_nxt  = new_slot_r;

    ring_we    = 1'b0;
    ring_waddr = push_r[SLOT_BITS-1:0];
    ring_wdata = h_slot;
    ring_re    = in_acc;
    slot_we    = 1'b0;
    slot_waddr = h_slot;
    slot_wdata = {slot_gen + GEN_W'(1), slot_kind, slot_pos};
    slot_re    = in_acc;
    slot_raddr = in_entity_handle[SLOT_BITS-1:0];
    kt_we      = 1'b0;
    kt_new     = 1'b0;
    kt_widx    = sel_r[KIND_W-1:0];
    kt_wfill   = kt_rfill + POS_W'(1);
    kt_ridx    = (req_r == REQ_LOCATE) ? slot_kind : sel_r[KIND_W-1:0];

    unique case (state_r)
      S_CLR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_r;
        ring_wdata = clr_r + SLOT_BITS'(1);
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + SLOT_BITS'(1);
        if (clr_r == {SLOT_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rs_status_nxt = STAT_OK;
        rs_handle_nxt = '0;
        rs_ares_nxt   = '0;
        rs_pos_nxt    = '0;
        rs_size_nxt   = '0;
        rs_live_nxt   = 1'b0;
        state_nxt     = S_DONE;
        case (req_r)
          REQ_CREATE_ARCH: begin
            if (total_r < TOT_W'(MAX_KINDS)) begin
              kt_we       = 1'b1;
              kt_new      = 1'b1;
              kt_widx     = total_r[KIND_W-1:0];
              kt_wfill    = '0;
              rs_ares_nxt = ARES_W'(total_r);
              total_nxt   = total_r + TOT_W'(1);
            end else begin
              rs_status_nxt = STAT_TBL_FULL;
            end
          end
          REQ_CREATE_ENT: begin
            if (!(pop_r < push_r)) begin
              rs_status_nxt = STAT_NO_SLOT;
            end else if (CMP_W'(sel_r) >= CMP_W'(total_r)) begin
              rs_status_nxt = STAT_UNKNOWN;
            end else begin
              pop_nxt      = pop_r + POS_W'(1);
              slot_re      = 1'b1;
              slot_raddr   = ring_rdata;
              new_slot_nxt = ring_rdata;
              kt_we        = 1'b1;
              rs_pos_nxt   = kt_rfill;
              rs_size_nxt  = kt_rsize;
              rs_ares_nxt  = ARES_W'(sel_r);
              state_nxt    = S_GEN;
            end
          end
          REQ_DESTROY: begin
            if (handle_r != '0) begin
              slot_we  = 1'b1;
              ring_we  = 1'b1;
              push_nxt = push_r + POS_W'(1);
            end
          end
          REQ_EXISTS: begin
            rs_live_nxt = (h_gen == slot_gen);
          end
          REQ_LOCATE: begin
            if ((CMP_W'(slot_kind) < CMP_W'(total_r)) && (slot_pos < kt_rfill)) begin
              rs_ares_nxt = ARES_W'(slot_kind);
              rs_pos_nxt  = slot_pos;
              rs_size_nxt = kt_rsize;
              rs_live_nxt = (h_gen == slot_gen);
            end else begin
              rs_status_nxt = STAT_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_GEN: begin
        slot_we       = 1'b1;
        slot_waddr    = new_slot_r;
        slot_wdata    = {slot_gen, sel_r[KIND_W-1:0], rs_pos_r};
        rs_handle_nxt = {slot_gen, new_slot_r};
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = in_acc ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pop_r       <= '0;
      push_r      <= POS_W'((1 << SLOT_BITS) - 1);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pop_r   <= pop_nxt;
      push_r  <= push_nxt;
      total_r <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_req_type;
      handle_r <= in_entity_handle;
      sel_r    <= in_archetype_sel;
      size_r   <= in_element_size;
    end
    rs_status_r <= rs_status_nxt;
    rs_handle_r <= rs_handle_nxt;
    rs_ares_r   <= rs_ares_nxt;
    rs_pos_r    <= rs_pos_nxt;
    rs_size_r   <= rs_size_nxt;
    rs_live_r   <= rs_live_nxt;
    new_slot_r  <= new_slot_nxt;
    if (out_load) begin
      out_status_r <= rs_status_r;
      out_handle_r <= rs_handle_r;
      out_ares_r   <= rs_ares_r;
      out_pos_r    <= rs_pos_r;
      out_offs_r   <= prod[POS_W-1:0];
      out_live_r   <= rs_live_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_handle_result    = out_handle_r;
  assign out_archetype_result = out_ares_r;
  assign out_position         = out_pos_r;
  assign out_byte_offset      = out_offs_r;
  assign out_is_live          = out_live_r;

  // no request taken while the rams are being cleared
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("request accepted during clearing pass");

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_KINDS))
    else $error("archetype count beyond table depth");

  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted request not executed next cycle");

  a_pop_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(pop_r) |-> ($past(state_r) == S_EXEC) && ($past(req_r) == REQ_CREATE_ENT))
    else $error("pop pointer moved outside create entity");

endmodule
